@@ hw/rtl/cbyp_pkg.sv @@
// shared types and constants of the yaw/pitch camera basis block
// no dependencies; every other file of the block but cbyp_out_if uses this package
`default_nettype none

package cbyp_pkg;

    localparam int unsigned ANGLE_W    = 18;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned UP_W       = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CONSTRAIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_X      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Y      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Z      = 8'd3;

    // angles in 1/256 degree
    localparam logic signed [18:0] DEG90       = 19'sd23040;
    localparam logic signed [18:0] DEG180      = 19'sd46080;
    localparam logic signed [18:0] DEG360      = 19'sd92160;
    localparam logic signed [18:0] PITCH_LIMIT = 19'sd22784;
    localparam logic signed [17:0] YAW_RESET   = -18'sd23040;

    localparam logic signed [UP_W-1:0] UP_X_RESET = 16'sd0;
    localparam logic signed [UP_W-1:0] UP_Y_RESET = 16'sd32767;
    localparam logic signed [UP_W-1:0] UP_Z_RESET = 16'sd0;

    // cordic start value: gain 0.607252935 in Q2.30
    localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;
    localparam logic [21:0]        ATAN_SMALL = 22'd3754936;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [UP_W-1:0]    up_x;
        logic signed [UP_W-1:0]    up_y;
        logic signed [UP_W-1:0]    up_z;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic [21:0] atan_step(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            default: v = ATAN_SMALL >> i;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cbyp_in_if.sv @@
// input channel of the camera basis block: yaw and pitch offsets
// depends on cbyp_pkg
`default_nettype none

interface cbyp_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [cbyp_pkg::OFFSET_W-1:0]     yaw_offset;
    logic signed [cbyp_pkg::OFFSET_W-1:0]     pitch_offset;

    modport source (output valid, output yaw_offset, output pitch_offset, input ready);
    modport sink   (input valid, input yaw_offset, input pitch_offset, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbyp_cfg_if.sv @@
// configuration write channel of the camera basis block
// depends on cbyp_pkg
`default_nettype none

interface cbyp_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [cbyp_pkg::CFG_IDX_W-1:0]       index;
    logic [cbyp_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbyp_out_if.sv @@
// result channel of the camera basis block: front, right, up and degenerate
// no dependencies
`default_nettype none

interface cbyp_out_if #(
    parameter int VECTOR_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [VECTOR_BITS-1:0]        front_x;
    logic [VECTOR_BITS-1:0]        front_y;
    logic [VECTOR_BITS-1:0]        front_z;
    logic [VECTOR_BITS-1:0]        right_x;
    logic [VECTOR_BITS-1:0]        right_y;
    logic [VECTOR_BITS-1:0]        right_z;
    logic [VECTOR_BITS-1:0]        up_x;
    logic [VECTOR_BITS-1:0]        up_y;
    logic [VECTOR_BITS-1:0]        up_z;
    logic                          degenerate;

    modport source (output valid, output front_x, output front_y, output front_z,
                    output right_x, output right_y, output right_z,
                    output up_x, output up_y, output up_z, output degenerate,
                    input ready);
    modport sink   (input valid, input front_x, input front_y, input front_z,
                    input right_x, input right_y, input right_z,
                    input up_x, input up_y, input up_z, input degenerate,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbyp_front.sv @@
// front end: configuration registers, angle accumulation, wrap and clamp
// depends on cbyp_pkg, cbyp_in_if, cbyp_cfg_if
`default_nettype none

module cbyp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cbyp_in_if.sink            item,
    cbyp_cfg_if.sink           cfg,
    output cbyp_pkg::queue_wr_t wr_ctl,
    input  wire logic          queue_full,
    output cbyp_pkg::job_t     job
);

    logic                                 constrain_reg;
    logic signed [cbyp_pkg::UP_W-1:0]     up_x_reg;
    logic signed [cbyp_pkg::UP_W-1:0]     up_y_reg;
    logic signed [cbyp_pkg::UP_W-1:0]     up_z_reg;
    logic signed [cbyp_pkg::ANGLE_W-1:0]  yaw_reg;
    logic signed [cbyp_pkg::ANGLE_W-1:0]  pitch_reg;

    logic signed [18:0] yaw_sum, yaw_hi, yaw_next;
    logic signed [18:0] pit_sum, pit_hi, pit_wrap, pit_clamp, pit_next;
    logic               accept;

    assign cfg.ready  = 1'b1;
    assign item.ready = !queue_full;
    assign accept     = item.valid && !queue_full;

    always_comb
    begin
        yaw_sum = 19'(yaw_reg) + 19'(item.yaw_offset);
        pit_sum = 19'(pitch_reg) + 19'(item.pitch_offset);

        // wrap: first the upper bound, then the lower one
        yaw_hi   = (yaw_sum >= cbyp_pkg::DEG90) ? yaw_sum - cbyp_pkg::DEG360 : yaw_sum;
        yaw_next = (yaw_hi < -cbyp_pkg::DEG90) ? yaw_hi + cbyp_pkg::DEG360 : yaw_hi;

        pit_hi   = (pit_sum >= cbyp_pkg::DEG90) ? pit_sum - cbyp_pkg::DEG360 : pit_sum;
        pit_wrap = (pit_hi < -cbyp_pkg::DEG90) ? pit_hi + cbyp_pkg::DEG360 : pit_hi;

        pit_clamp = pit_sum;
        if (pit_sum > cbyp_pkg::PITCH_LIMIT)
        begin
            pit_clamp = cbyp_pkg::PITCH_LIMIT;
        end
        if (pit_sum < -cbyp_pkg::PITCH_LIMIT)
        begin
            pit_clamp = -cbyp_pkg::PITCH_LIMIT;
        end
        pit_next = constrain_reg ? pit_clamp : pit_wrap;

        job.yaw   = yaw_next[cbyp_pkg::ANGLE_W-1:0];
        job.pitch = pit_next[cbyp_pkg::ANGLE_W-1:0];
        job.up_x  = up_x_reg;
        job.up_y  = up_y_reg;
        job.up_z  = up_z_reg;

        wr_ctl.push = accept;
        wr_ctl.full = queue_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constrain_reg <= 1'b1;
            up_x_reg      <= cbyp_pkg::UP_X_RESET;
            up_y_reg      <= cbyp_pkg::UP_Y_RESET;
            up_z_reg      <= cbyp_pkg::UP_Z_RESET;
            yaw_reg       <= cbyp_pkg::YAW_RESET;
            pitch_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    cbyp_pkg::REG_CONSTRAIN: constrain_reg <= cfg.data[0];
                    cbyp_pkg::REG_UP_X:      up_x_reg <= cfg.data;
                    cbyp_pkg::REG_UP_Y:      up_y_reg <= cfg.data;
                    cbyp_pkg::REG_UP_Z:      up_z_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                yaw_reg   <= job.yaw;
                pitch_reg <= job.pitch;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cbyp_queue.sv @@
// two-entry job queue between the front end and the vector engine
// depends on cbyp_pkg
`default_nettype none

module cbyp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbyp_pkg::queue_wr_t wr_ctl,
    input  wire cbyp_pkg::job_t      wr_job,
    output logic                     full,
    output logic                     rd_valid,
    output cbyp_pkg::job_t           rd_job,
    input  wire logic                pop
);

    localparam int unsigned PTR_W = $clog2(cbyp_pkg::QUEUE_DEPTH);

    cbyp_pkg::job_t       mem [cbyp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == (PTR_W+1)'(cbyp_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign do_push  = wr_ctl.push && !wr_ctl.full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cbyp_back.sv @@
// vector engine: cordic sin/cos, front vector, cross products, normalization
// with a bit-serial square root and divider; depends on cbyp_pkg, cbyp_out_if
`default_nettype none

module cbyp_back #(
    parameter int VECTOR_BITS    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire cbyp_pkg::job_t  job,
    output logic                 job_pop,
    cbyp_out_if.source           result
);

    localparam int STEP_W  = (ROTATION_STEPS > 1) ? $clog2(ROTATION_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROTATION_STEPS - 1);
    localparam int SHIFT   = 31 - VECTOR_BITS;
    localparam int SHIFT_P = (SHIFT > 0) ? SHIFT : 1;
    localparam logic signed [33:0] ROUND  = 34'sd1 <<< (SHIFT_P - 1);
    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (VECTOR_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORDIC, ST_FRONT, ST_CROSS, ST_MAG, ST_TOP,
        ST_SHIFT, ST_SQ, ST_SQRT, ST_DIV, ST_NEXT, ST_OUT
    } state_t;

    // control
    state_t              state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                pass_reg, pass_next;
    logic [1:0]          comp_reg, comp_next;
    logic                res_valid_reg, res_valid_next;

    // datapath
    logic signed [33:0]  x_reg [2], x_next [2];
    logic signed [33:0]  y_reg [2], y_next [2];
    logic signed [27:0]  z_reg [2], z_next [2];
    logic                neg_reg [2], neg_next [2];
    logic signed [31:0]  va_reg [3], va_next [3];
    logic signed [31:0]  vb_reg [3], vb_next [3];
    logic signed [31:0]  f_reg [3], f_next [3];
    logic signed [31:0]  r_reg [3], r_next [3];
    logic signed [31:0]  nres_reg [3], nres_next [3];
    logic signed [63:0]  acc_reg [3], acc_next [3];
    logic [63:0]         mag_reg [3], mag_next [3];
    logic                sgn_reg [3], sgn_next [3];
    logic [63:0]         top_reg, top_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic [63:0]         sum_reg, sum_next;
    logic [63:0]         sq_n_reg, sq_n_next;
    logic [63:0]         sq_res_reg, sq_res_next;
    logic [63:0]         sq_bit_reg, sq_bit_next;
    logic [30:0]         len_reg, len_next;
    logic [30:0]         rem_reg, rem_next;
    logic [30:0]         quo_reg, quo_next;
    logic                deg_reg, deg_next;

    // result register
    logic [VECTOR_BITS-1:0] out_reg [9], out_next [9];
    logic                   out_deg_reg, out_deg_next;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;

    function automatic logic [VECTOR_BITS-1:0] to_out(input logic signed [31:0] v);
        logic signed [33:0] t;
        t = 34'(v);
        if (SHIFT > 0)
        begin
            t = (t + ROUND) >>> SHIFT_P;
        end
        else if (SHIFT < 0)
        begin
            t = t <<< 1;
        end
        if (t > SAT_HI)
        begin
            t = SAT_HI;
        end
        if (t < SAT_LO)
        begin
            t = SAT_LO;
        end
        return t[VECTOR_BITS-1:0];
    endfunction

    assign mul_p = mul_a * mul_b;

    assign result.valid      = res_valid_reg;
    assign result.front_x    = out_reg[0];
    assign result.front_y    = out_reg[1];
    assign result.front_z    = out_reg[2];
    assign result.right_x    = out_reg[3];
    assign result.right_y    = out_reg[4];
    assign result.right_z    = out_reg[5];
    assign result.up_x       = out_reg[6];
    assign result.up_y       = out_reg[7];
    assign result.up_z       = out_reg[8];
    assign result.degenerate = out_deg_reg;

    always_comb
    begin
        logic signed [18:0] ang;
        logic               fneg;
        logic signed [33:0] dx, dy;
        logic signed [27:0] at;
        logic signed [33:0] xn, yn;
        logic [2:0]         term;
        logic [1:0]         kk;
        logic [63:0]        trial_sum;
        logic               dbit;
        logic [31:0]        trial;
        logic [30:0]        half_len;
        logic [30:0]        quo_new;
        logic [63:0]        top01;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        comp_next      = comp_reg;
        res_valid_next = res_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        neg_next       = neg_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        f_next         = f_reg;
        r_next         = r_reg;
        nres_next      = nres_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        sgn_next       = sgn_reg;
        top_next       = top_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        sq_n_next      = sq_n_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        deg_next       = deg_reg;
        out_next       = out_reg;
        out_deg_next   = out_deg_reg;
        job_pop        = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        ang            = '0;
        fneg           = 1'b0;
        dx             = '0;
        dy             = '0;
        at             = '0;
        xn             = '0;
        yn             = '0;
        term           = '0;
        kk             = '0;
        trial_sum      = '0;
        dbit           = 1'b0;
        trial          = '0;
        half_len       = len_reg >> 1;
        quo_new        = '0;
        top01          = '0;

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    for (int l = 0; l < 2; l++)
                    begin
                        ang  = (l == 0) ? 19'(job.yaw) : 19'(job.pitch);
                        fneg = 1'b0;
                        // fold into [-90,90], negate the results later
                        if (ang > cbyp_pkg::DEG90)
                        begin
                            ang  = ang - cbyp_pkg::DEG180;
                            fneg = 1'b1;
                        end
                        else if (ang < -cbyp_pkg::DEG90)
                        begin
                            ang  = ang + cbyp_pkg::DEG180;
                            fneg = 1'b1;
                        end
                        x_next[l]   = cbyp_pkg::GAIN_Q30;
                        y_next[l]   = '0;
                        z_next[l]   = 28'(ang) <<< 8;
                        neg_next[l] = fneg;
                    end
                    vb_next[0] = 32'(job.up_x);
                    vb_next[1] = 32'(job.up_y);
                    vb_next[2] = 32'(job.up_z);
                    deg_next   = 1'b0;
                    step_next  = '0;
                    state_next = ST_CORDIC;
                end
            end

            ST_CORDIC:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    dx = y_reg[l] >>> step_reg;
                    dy = x_reg[l] >>> step_reg;
                    at = 28'(cbyp_pkg::atan_step(5'(step_reg)));
                    if (!z_reg[l][27])
                    begin
                        xn = x_reg[l] - dx;
                        yn = y_reg[l] + dy;
                        z_next[l] = z_reg[l] - at;
                    end
                    else
                    begin
                        xn = x_reg[l] + dx;
                        yn = y_reg[l] - dy;
                        z_next[l] = z_reg[l] + at;
                    end
                    if (step_reg == STEP_LAST && neg_reg[l])
                    begin
                        xn = -xn;
                        yn = -yn;
                    end
                    x_next[l] = xn;
                    y_next[l] = yn;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FRONT;
                end
            end

            ST_FRONT:
            begin
                // cos yaw * cos pitch, then sin yaw * cos pitch
                mul_a     = (cnt_reg == 6'd0) ? x_reg[0][31:0] : y_reg[0][31:0];
                mul_b     = x_reg[1][31:0];
                prod_next = mul_p;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    f_next[0] = 32'(prod_reg >>> 30);
                end
                if (cnt_reg == 6'd2)
                begin
                    f_next[1]  = y_reg[1][31:0];
                    f_next[2]  = 32'(prod_reg >>> 30);
                    va_next[0] = f_reg[0];
                    va_next[1] = y_reg[1][31:0];
                    va_next[2] = 32'(prod_reg >>> 30);
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    pass_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
            end

            ST_CROSS:
            begin
                // cross va x vb, one product a cycle, each accumulated in the cycle after
                case (cnt_reg[2:0])
                    3'd0: begin mul_a = va_reg[1]; mul_b = vb_reg[2]; end
                    3'd1: begin mul_a = va_reg[2]; mul_b = vb_reg[1]; end
                    3'd2: begin mul_a = va_reg[2]; mul_b = vb_reg[0]; end
                    3'd3: begin mul_a = va_reg[0]; mul_b = vb_reg[2]; end
                    3'd4: begin mul_a = va_reg[0]; mul_b = vb_reg[1]; end
                    3'd5: begin mul_a = va_reg[1]; mul_b = vb_reg[0]; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                prod_next = mul_p;
                if (cnt_reg != 6'd0)
                begin
                    term = 3'(cnt_reg - 6'd1);
                    kk   = 2'(term >> 1);
                    if (term[0])
                    begin
                        acc_next[kk] = acc_reg[kk] - prod_reg;
                    end
                    else
                    begin
                        acc_next[kk] = acc_reg[kk] + prod_reg;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd6)
                begin
                    state_next = ST_MAG;
                end
            end

            ST_MAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sgn_next[k] = acc_reg[k][63];
                    mag_next[k] = acc_reg[k][63] ? 64'(-acc_reg[k]) : 64'(acc_reg[k]);
                end
                state_next = ST_TOP;
            end

            ST_TOP:
            begin
                top01    = (mag_reg[1] > mag_reg[0]) ? mag_reg[1] : mag_reg[0];
                top_next = (mag_reg[2] > top01) ? mag_reg[2] : top01;
                if (top_next == '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        nres_next[k] = '0;
                    end
                    if (!pass_reg)
                    begin
                        deg_next = 1'b1;
                    end
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (top_reg[63:30] != '0)
                begin
                    top_next = top_reg >> 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_next[k] = mag_reg[k] >> 1;
                    end
                end
                else if (!top_reg[29])
                begin
                    top_next = top_reg << 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_next[k] = mag_reg[k] << 1;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end

            ST_SQ:
            begin
                if (cnt_reg < 6'd3)
                begin
                    mul_a = $signed(mag_reg[cnt_reg[1:0]][31:0]);
                    mul_b = $signed(mag_reg[cnt_reg[1:0]][31:0]);
                end
                prod_next = mul_p;
                if (cnt_reg != 6'd0)
                begin
                    sum_next = sum_reg + 64'(prod_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd3)
                begin
                    sq_n_next   = sum_reg + 64'(prod_reg);
                    sq_res_next = '0;
                    sq_bit_next = 64'd1 << 62;
                    cnt_next    = '0;
                    state_next  = ST_SQRT;
                end
            end

            ST_SQRT:
            begin
                trial_sum = sq_res_reg + sq_bit_reg;
                if (sq_n_reg >= trial_sum)
                begin
                    sq_n_next   = sq_n_reg - trial_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 6'd31)
                begin
                    len_next   = sq_res_next[30:0];
                    comp_next  = '0;
                    rem_next   = 31'(mag_reg[0] >> 1);
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // dividend is mag*2^30 + len/2: bit 30 is mag[0], below it len/2
                if (cnt_reg == 6'd0)
                begin
                    dbit = mag_reg[comp_reg][0];
                end
                else
                begin
                    dbit = half_len[5'(6'd30 - cnt_reg)];
                end
                trial = {rem_reg, dbit};
                if (trial >= 32'(len_reg))
                begin
                    rem_next = 31'(trial - 32'(len_reg));
                    quo_new  = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[30:0];
                    quo_new  = {quo_reg[29:0], 1'b0};
                end
                quo_next = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd30)
                begin
                    nres_next[comp_reg] = sgn_reg[comp_reg] ? -32'(quo_new) : 32'(quo_new);
                    cnt_next = '0;
                    quo_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        comp_next = comp_reg + 1'b1;
                        rem_next  = 31'(mag_reg[comp_reg + 1'b1] >> 1);
                    end
                end
            end

            ST_NEXT:
            begin
                if (!pass_reg)
                begin
                    // right is done: up = right x front
                    r_next  = nres_reg;
                    va_next = nres_reg;
                    vb_next = f_reg;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    pass_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CROSS;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        out_next[k]     = to_out(f_reg[k]);
                        out_next[3 + k] = to_out(r_reg[k]);
                        out_next[6 + k] = to_out(nres_reg[k]);
                    end
                    out_deg_next   = deg_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            comp_reg      <= '0;
            res_valid_reg <= 1'b0;
            out_deg_reg   <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                out_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            comp_reg      <= comp_next;
            res_valid_reg <= res_valid_next;
            out_deg_reg   <= out_deg_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        neg_reg    <= neg_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        f_reg      <= f_next;
        r_reg      <= r_next;
        nres_reg   <= nres_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        sgn_reg    <= sgn_next;
        top_reg    <= top_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        deg_reg    <= deg_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/camera_basis_from_yaw_pitch.sv @@
// Yaw/pitch camera basis block.
// Channel item carries yaw_offset and pitch_offset (1/256 degree); each accepted
// item updates the stored yaw and pitch and yields one item on channel result:
// front, right and up as signed Q1.(VECTOR_BITS-1) vectors plus degenerate,
// which is set when front is parallel to world up (right and up are then zero).
// Channel cfg writes constrain_pitch (index 0) and world_up x/y/z (1..3); it is
// always ready, other indexes are ignored. Write it only while the block is idle.
// The time from item acceptance to result valid grows with ROTATION_STEPS and
// with the normalizing shifts of the right and up passes. The two bit-serial
// units, the square root and the divider (once per vector component), run for
// right and then for up; a degenerate right skips both in both passes.
// One item is processed at a time; a two-entry queue lets the front end take
// further items meanwhile, and the result register lets the next item be
// computed while a result waits on a stalled receiver.
// After reset: constrain_pitch 1, world up (0, 32767, 0), yaw -90 degrees,
// pitch 0, queue empty, no result pending.
// depends on cbyp_pkg, cbyp_in_if, cbyp_cfg_if, cbyp_out_if, cbyp_front,
// cbyp_queue, cbyp_back
`default_nettype none

module camera_basis_from_yaw_pitch #(
    parameter int VECTOR_BITS    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbyp_in_if.sink     item,
    cbyp_cfg_if.sink    cfg,
    cbyp_out_if.source  result
);

    cbyp_pkg::queue_wr_t wr_ctl;
    cbyp_pkg::job_t      wr_job;
    cbyp_pkg::job_t      rd_job;
    logic                queue_full;
    logic                rd_valid;
    logic                pop;

    cbyp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .wr_ctl     (wr_ctl),
        .queue_full (queue_full),
        .job        (wr_job)
    );

    cbyp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_ctl   (wr_ctl),
        .wr_job   (wr_job),
        .full     (queue_full),
        .rd_valid (rd_valid),
        .rd_job   (rd_job),
        .pop      (pop)
    );

    cbyp_back #(
        .VECTOR_BITS    (VECTOR_BITS),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (rd_valid),
        .job       (rd_job),
        .job_pop   (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
